/* rtl/r2y_pkg.sv */
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// No dependencies; used by r2y_front, r2y_math and the top level.
package r2y_pkg;

   // CSR map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] LINE_WIDTH_RESET   = 12'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_MIN         = 12'd2;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_MAX         = 12'd2048;

   localparam int ROW_W  = 11;
   localparam int PIX_W  = 8;
   localparam int PAIR_W = 9;
   localparam int PROD_W = 24;

   // Q16 coefficients, magnitudes only; signs are applied in the adders
   localparam logic [PROD_W-1:0] COEF_Y_R  = 24'd16843;
   localparam logic [PROD_W-1:0] COEF_Y_G  = 24'd33030;
   localparam logic [PROD_W-1:0] COEF_Y_B  = 24'd6423;
   localparam logic [PROD_W-1:0] COEF_CB_R = 24'd9699;
   localparam logic [PROD_W-1:0] COEF_CB_G = 24'd19071;
   localparam logic [PROD_W-1:0] COEF_CB_B = 24'd28770;
   localparam logic [PROD_W-1:0] COEF_CR_R = 24'd28770;
   localparam logic [PROD_W-1:0] COEF_CR_G = 24'd24117;
   localparam logic [PROD_W-1:0] COEF_CR_B = 24'd4653;
   localparam logic [PROD_W-1:0] Y_OFFSET  = 24'd1048576;  // 16 << 16
   localparam logic [PROD_W-1:0] C_OFFSET  = 24'd8388608;  // 128 << 16

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pix_type;

   // horizontal sums of one pixel pair, one line memory entry
   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_type;

   localparam int PAIR_WORD_W = $bits(pair_type);

   typedef struct packed {
      logic chroma_valid;
      logic last_of_frame;
   } ctl_type;

   typedef struct packed {
      pix_type  pix;
      pair_type hsum;
      ctl_type  ctl;
   } s1_type;

endpackage

/* rtl/r2y_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module r2y_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/r2y_front.sv */
// Input stage: raster position counters, pixel pairing and line memory access.
// Depends on r2y_pkg and r2y_ram.
module r2y_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [r2y_pkg::CSR_DATA_W-1:0]   line_width,
   input  logic [r2y_pkg::CSR_DATA_W-1:0]   frame_height,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [r2y_pkg::PIX_W-1:0]        req_blue,
   input  logic [r2y_pkg::PIX_W-1:0]        req_green,
   input  logic [r2y_pkg::PIX_W-1:0]        req_red,
   output logic                             s1_valid,
   input  logic                             s1_ready,
   output r2y_pkg::s1_type                  s1_word,
   output r2y_pkg::pair_type                pair_rdata
);

   localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int IDX_W      = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int CNT_W      = $clog2(MAX_WIDTH) + 1;
   localparam int CMP_W      = (CNT_W > r2y_pkg::CSR_DATA_W) ? CNT_W : r2y_pkg::CSR_DATA_W;

   logic [CNT_W-1:0]          col_ff, col_in;
   logic [r2y_pkg::ROW_W-1:0] row_ff, row_in;
   r2y_pkg::pix_type          left_ff, left_in;
   logic                      s1_valid_ff, s1_valid_in;
   r2y_pkg::s1_type           s1_word_ff;

   logic                          accept;
   r2y_pkg::pix_type              pix_cur;
   r2y_pkg::pair_type             hsum;
   logic [CMP_W-1:0]              lw_ext, w_clamp;
   logic [CNT_W-1:0]              w_m1;
   logic [r2y_pkg::CSR_DATA_W-1:0] h_clamp;
   logic [r2y_pkg::ROW_W-1:0]     h_m1;
   logic                          end_line, end_frame;
   logic                          pair_wr, pair_rd;
   logic [IDX_W-1:0]              pair_addr;
   logic [r2y_pkg::PAIR_WORD_W-1:0] pair_rd_raw;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pix_cur.red   = req_red;
      pix_cur.green = req_green;
      pix_cur.blue  = req_blue;
      hsum.red   = {1'b0, left_ff.red}   + {1'b0, req_red};
      hsum.green = {1'b0, left_ff.green} + {1'b0, req_green};
      hsum.blue  = {1'b0, left_ff.blue}  + {1'b0, req_blue};

      lw_ext = CMP_W'(line_width);
      if (lw_ext < CMP_W'(2)) begin
         w_clamp = CMP_W'(2);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         w_clamp = CMP_W'(MAX_WIDTH);
      end else begin
         w_clamp = lw_ext;
      end
      w_m1 = CNT_W'(w_clamp - CMP_W'(1));

      if (frame_height < r2y_pkg::HEIGHT_MIN) begin
         h_clamp = r2y_pkg::HEIGHT_MIN;
      end else if (frame_height > r2y_pkg::HEIGHT_MAX) begin
         h_clamp = r2y_pkg::HEIGHT_MAX;
      end else begin
         h_clamp = frame_height;
      end
      h_m1 = r2y_pkg::ROW_W'(h_clamp - 12'd1);

      end_line  = col_ff >= w_m1;
      end_frame = end_line && (row_ff >= h_m1);

      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (accept) begin
         left_in = pix_cur;
         if (end_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (end_line) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Even row stores the pair sum, odd row reads it back one line later. The
   // same entry is never read sooner than two words after its write.
   assign pair_addr = col_ff[IDX_W:1];
   assign pair_wr   = accept && col_ff[0] && !row_ff[0];
   assign pair_rd   = accept && col_ff[0] && row_ff[0];

   r2y_ram #(
      .WIDTH (r2y_pkg::PAIR_WORD_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr),
      .wr_addr (pair_addr),
      .wr_data (hsum),
      .rd_en   (pair_rd),
      .rd_addr (pair_addr),
      .rd_data (pair_rd_raw)
   );

   assign pair_rdata = r2y_pkg::pair_type'(pair_rd_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff.pix              <= pix_cur;
         s1_word_ff.hsum             <= hsum;
         s1_word_ff.ctl.chroma_valid <= col_ff[0] && row_ff[0];
         s1_word_ff.ctl.last_of_frame <= end_frame;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_word  = s1_word_ff;

endmodule

/* rtl/r2y_math.sv */
// Color math pipeline: luma, 2x2 chroma averaging and Cb/Cr, with output register.
// Depends on r2y_pkg.
module r2y_math (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       s1_valid,
   output logic                       s1_ready,
   input  r2y_pkg::s1_type            s1_word,
   input  r2y_pkg::pair_type          pair_rdata,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [r2y_pkg::PIX_W-1:0]  rsp_luma,
   output logic                       rsp_chroma_valid,
   output logic [r2y_pkg::PIX_W-1:0]  rsp_cb,
   output logic [r2y_pkg::PIX_W-1:0]  rsp_cr,
   output logic                       rsp_last_of_frame
);

   localparam int PW = r2y_pkg::PROD_W;

   logic s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s2_ready, s3_ready, s4_ready;

   // stage 2: luma products and block averages
   logic [PW-1:0]              s2_yr_ff, s2_yg_ff, s2_yb_ff;
   logic [r2y_pkg::PIX_W-1:0]  s2_ar_ff, s2_ag_ff, s2_ab_ff;
   r2y_pkg::ctl_type           s2_ctl_ff;
   // stage 3: luma and chroma products
   logic [r2y_pkg::PIX_W-1:0]  s3_luma_ff;
   logic [PW-1:0]              s3_cbr_ff, s3_cbg_ff, s3_cbb_ff;
   logic [PW-1:0]              s3_crr_ff, s3_crg_ff, s3_crb_ff;
   r2y_pkg::ctl_type           s3_ctl_ff;
   // stage 4: output register
   logic [r2y_pkg::PIX_W-1:0]  s4_luma_ff, s4_cb_ff, s4_cr_ff;
   r2y_pkg::ctl_type           s4_ctl_ff;

   logic [r2y_pkg::PAIR_W:0]   sum_r, sum_g, sum_b;
   logic [PW-1:0]              y_sum, cb_sum, cr_sum;

   assign s4_ready = !s4_valid_ff || rsp_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = s2_ready;

   always_comb begin
      sum_r  = {1'b0, pair_rdata.red}   + {1'b0, s1_word.hsum.red};
      sum_g  = {1'b0, pair_rdata.green} + {1'b0, s1_word.hsum.green};
      sum_b  = {1'b0, pair_rdata.blue}  + {1'b0, s1_word.hsum.blue};
      y_sum  = s2_yr_ff + s2_yg_ff + s2_yb_ff + r2y_pkg::Y_OFFSET;
      // all terms stay in 0..255 << 16, so modulo 2^24 arithmetic is exact
      cb_sum = r2y_pkg::C_OFFSET + s3_cbb_ff - s3_cbr_ff - s3_cbg_ff;
      cr_sum = r2y_pkg::C_OFFSET + s3_crr_ff - s3_crg_ff - s3_crb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= s1_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         s2_yr_ff  <= PW'(s1_word.pix.red)   * r2y_pkg::COEF_Y_R;
         s2_yg_ff  <= PW'(s1_word.pix.green) * r2y_pkg::COEF_Y_G;
         s2_yb_ff  <= PW'(s1_word.pix.blue)  * r2y_pkg::COEF_Y_B;
         s2_ar_ff  <= sum_r[r2y_pkg::PAIR_W:2];
         s2_ag_ff  <= sum_g[r2y_pkg::PAIR_W:2];
         s2_ab_ff  <= sum_b[r2y_pkg::PAIR_W:2];
         s2_ctl_ff <= s1_word.ctl;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_luma_ff <= y_sum[PW-1:16];
         s3_cbr_ff  <= PW'(s2_ar_ff) * r2y_pkg::COEF_CB_R;
         s3_cbg_ff  <= PW'(s2_ag_ff) * r2y_pkg::COEF_CB_G;
         s3_cbb_ff  <= PW'(s2_ab_ff) * r2y_pkg::COEF_CB_B;
         s3_crr_ff  <= PW'(s2_ar_ff) * r2y_pkg::COEF_CR_R;
         s3_crg_ff  <= PW'(s2_ag_ff) * r2y_pkg::COEF_CR_G;
         s3_crb_ff  <= PW'(s2_ab_ff) * r2y_pkg::COEF_CR_B;
         s3_ctl_ff  <= s2_ctl_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_luma_ff <= s3_luma_ff;
         s4_cb_ff   <= s3_ctl_ff.chroma_valid ? cb_sum[PW-1:16] : '0;
         s4_cr_ff   <= s3_ctl_ff.chroma_valid ? cr_sum[PW-1:16] : '0;
         s4_ctl_ff  <= s3_ctl_ff;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_luma          = s4_luma_ff;
   assign rsp_chroma_valid  = s4_ctl_ff.chroma_valid;
   assign rsp_cb            = s4_cb_ff;
   assign rsp_cr            = s4_cr_ff;
   assign rsp_last_of_frame = s4_ctl_ff.last_of_frame;

endmodule

/* rtl/rgb_to_yuv420_converter_core.sv */
// Top level of the RGB to YCbCr 4:2:0 converter: CSRs and the two pipeline halves.
// Depends on r2y_pkg, r2y_front, r2y_math (and r2y_ram through r2y_front).

// Takes one RGB pixel per clock in raster order unless rsp_ready stalls the
// pipeline, and returns one word per pixel with its BT.601 luma; on the
// bottom-right pixel of each 2x2 block the word also carries Cb and Cr of the
// block average. Throughput is one pixel per cycle while rsp_ready does not
// hold the pipeline. Each word passes the first stage register with the line
// memory read, the two multiplier stages and the output register.
// The line memory holds (MAX_WIDTH+1)/2 pair sums and needs no clearing pass
// after reset. CSR writes are always accepted and apply from the next pixel;
// change them only between frames.
module rgb_to_yuv420_converter_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [r2y_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [r2y_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [r2y_pkg::PIX_W-1:0]        req_blue,
   input  logic [r2y_pkg::PIX_W-1:0]        req_green,
   input  logic [r2y_pkg::PIX_W-1:0]        req_red,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [r2y_pkg::PIX_W-1:0]        rsp_luma,
   output logic                             rsp_chroma_valid,
   output logic [r2y_pkg::PIX_W-1:0]        rsp_cb,
   output logic [r2y_pkg::PIX_W-1:0]        rsp_cr,
   output logic                             rsp_last_of_frame
);

   logic [r2y_pkg::CSR_DATA_W-1:0] line_width_ff, line_width_in;
   logic [r2y_pkg::CSR_DATA_W-1:0] frame_height_ff, frame_height_in;
   logic                           csr_write;

   logic              s1_valid, s1_ready;
   r2y_pkg::s1_type   s1_word;
   r2y_pkg::pair_type pair_rdata;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            r2y_pkg::CSR_LINE_WIDTH:   line_width_in   = csr_wdata;
            r2y_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= r2y_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= r2y_pkg::FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   r2y_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_blue     (req_blue),
      .req_green    (req_green),
      .req_red      (req_red),
      .s1_valid     (s1_valid),
      .s1_ready     (s1_ready),
      .s1_word      (s1_word),
      .pair_rdata   (pair_rdata)
   );

   r2y_math u_math (
      .clock             (clock),
      .reset             (reset),
      .s1_valid          (s1_valid),
      .s1_ready          (s1_ready),
      .s1_word           (s1_word),
      .pair_rdata        (pair_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_luma          (rsp_luma),
      .rsp_chroma_valid  (rsp_chroma_valid),
      .rsp_cb            (rsp_cb),
      .rsp_cr            (rsp_cr),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

`ifndef SYNTHESIS
   // chroma fields are zeroed on words without a completed block
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chroma_valid |-> rsp_cb == '0 && rsp_cr == '0)
      else $error("cb/cr not zero on a word without chroma");

   // an accepted pixel always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid)
      else $error("accepted pixel lost before first stage");

   // a stalled first stage keeps its word and, on a chroma word, the line memory data
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !s1_ready |=> s1_valid && $stable(s1_word) &&
      (!s1_word.ctl.chroma_valid || $stable(pair_rdata)))
      else $error("first stage word changed while stalled");
`endif

endmodule
